[sv/erlwa_pkg.sv]
package erlwa_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [2:0] REG_TRIGGER_START  = 3'd0;
    localparam logic [2:0] REG_TRIGGER_END    = 3'd1;
    localparam logic [2:0] REG_ECHO_MIN_TICKS = 3'd2;
    localparam logic [2:0] REG_ECHO_MAX_TICKS = 3'd3;
    localparam logic [2:0] REG_LIMIT_CEILING  = 3'd4;
    localparam logic [2:0] REG_LIMIT_STEP     = 3'd5;

    localparam logic [15:0] TRIGGER_START_RST  = 16'd3500;
    localparam logic [15:0] TRIGGER_END_RST    = 16'd3502;
    localparam logic [15:0] ECHO_MIN_TICKS_RST = 16'd10;
    localparam logic [15:0] ECHO_MAX_TICKS_RST = 16'd6000;
    localparam logic [11:0] LIMIT_CEILING_RST  = 12'd2000;
    localparam logic [6:0]  LIMIT_STEP_RST     = 7'd10;
    localparam logic [11:0] MAX_LIMIT_RST      = 12'd1000;

    // floor(w * 1700 / 10000) = (w * 17 * ceil(2^32 / 100)) >> 32 for 16-bit w
    localparam logic [29:0] LEVEL_MUL   = 30'd730144441;
    localparam int          LEVEL_SHIFT = 32;

    typedef struct packed {
        logic func;
        logic echo_high;
        logic key_max_up;
        logic key_max_down;
        logic key_min_up;
        logic key_min_down;
    } req_word_t;

    typedef struct packed {
        logic        trigger_out;
        logic        alarm_out;
        logic [13:0] level_mm;
        logic        report_valid;
        logic [11:0] report_value;
    } res_word_t;

    typedef struct packed {
        logic [15:0] trigger_start;
        logic [15:0] trigger_end;
        logic [15:0] echo_min_ticks;
        logic [15:0] echo_max_ticks;
        logic [11:0] limit_ceiling;
        logic [6:0]  limit_step;
    } cfg_t;

endpackage

[sv/erlwa_cfg_regs.sv]
module erlwa_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [erlwa_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [erlwa_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [erlwa_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                  pready,
    output erlwa_pkg::cfg_t                       cfg
);

    erlwa_pkg::cfg_t cfg_reg;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_start  <= erlwa_pkg::TRIGGER_START_RST;
            cfg_reg.trigger_end    <= erlwa_pkg::TRIGGER_END_RST;
            cfg_reg.echo_min_ticks <= erlwa_pkg::ECHO_MIN_TICKS_RST;
            cfg_reg.echo_max_ticks <= erlwa_pkg::ECHO_MAX_TICKS_RST;
            cfg_reg.limit_ceiling  <= erlwa_pkg::LIMIT_CEILING_RST;
            cfg_reg.limit_step     <= erlwa_pkg::LIMIT_STEP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                erlwa_pkg::REG_TRIGGER_START:  cfg_reg.trigger_start  <= pwdata[15:0];
                erlwa_pkg::REG_TRIGGER_END:    cfg_reg.trigger_end    <= pwdata[15:0];
                erlwa_pkg::REG_ECHO_MIN_TICKS: cfg_reg.echo_min_ticks <= pwdata[15:0];
                erlwa_pkg::REG_ECHO_MAX_TICKS: cfg_reg.echo_max_ticks <= pwdata[15:0];
                erlwa_pkg::REG_LIMIT_CEILING:  cfg_reg.limit_ceiling  <= pwdata[11:0];
                erlwa_pkg::REG_LIMIT_STEP:     cfg_reg.limit_step     <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            erlwa_pkg::REG_TRIGGER_START:  prdata = {16'd0, cfg_reg.trigger_start};
            erlwa_pkg::REG_TRIGGER_END:    prdata = {16'd0, cfg_reg.trigger_end};
            erlwa_pkg::REG_ECHO_MIN_TICKS: prdata = {16'd0, cfg_reg.echo_min_ticks};
            erlwa_pkg::REG_ECHO_MAX_TICKS: prdata = {16'd0, cfg_reg.echo_max_ticks};
            erlwa_pkg::REG_LIMIT_CEILING:  prdata = {20'd0, cfg_reg.limit_ceiling};
            erlwa_pkg::REG_LIMIT_STEP:     prdata = {25'd0, cfg_reg.limit_step};
            default:                       prdata = '0;
        endcase
    end

endmodule

[sv/erlwa_skid.sv]
module erlwa_skid
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  erlwa_pkg::res_word_t  load_word,
    output logic                  full,
    output logic                  res_valid,
    input  logic                  res_stall,
    output erlwa_pkg::res_word_t  res_data
);

    logic                 out_valid_reg;
    erlwa_pkg::res_word_t out_word_reg;
    logic                 skid_valid_reg;
    erlwa_pkg::res_word_t skid_word_reg;
    logic                 out_free;

    assign out_free  = !out_valid_reg || !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : load_word;
        end
        else if (load)
        begin
            skid_word_reg <= load_word;
        end
    end

endmodule

[sv/echo_ranger_level_window_alarm.sv]
// ultrasonic echo ranger with a level window alarm
//
// request channel (req_valid / req_stall / req_data): one tick word per cycle while req_stall is low;
//   func 0 is a fast ranging tick using echo_high, func 1 a slow key and
//   alarm tick using the four key presses
// result channel (res_valid / res_stall / res_data): exactly one word per
//   request word, in order, carrying trigger and alarm pins, the level in mm
//   and any limit change report
// result path: each result is registered in the result register, via the skid stage while stalled
// throughput: one word per cycle while req_stall is low; all state updates for a tick are settled
//   in the cycle it is taken, and the result register plus a one-word skid
//   stage let the next word in while a result waits
// stall: when the receiver stalls, one more word is taken into the skid
//   stage, then req_stall rises until the result register drains
// reset: counters, level and min limit clear, max limit goes to 1000, pins
//   low, configuration registers take their defaults, both buffers empty
// configuration: APB writes, one register per 4-byte slot, always ready;
//   write only while no result is outstanding
module echo_ranger_level_window_alarm
#(
    parameter int COUNT_BITS = erlwa_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  erlwa_pkg::req_word_t                req_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output erlwa_pkg::res_word_t                res_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [erlwa_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [erlwa_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [erlwa_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                pready
);

    localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int PROD_BITS = 46;

    erlwa_pkg::cfg_t      cfg;
    erlwa_pkg::res_word_t res_word;
    logic                 skid_full;
    logic                 req_fire;

    logic [COUNT_BITS-1:0] trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0] echo_w_reg, echo_w_next;
    logic [13:0]           level_reg, level_next;
    logic [11:0]           max_lim_reg, max_lim_next;
    logic [11:0]           min_lim_reg, min_lim_next;
    logic                  trig_pin_reg, trig_pin_next;
    logic                  alarm_pin_reg, alarm_pin_next;

    logic [COUNT_BITS-1:0] trig_inc;
    logic [COUNT_BITS-1:0] echo_inc;
    logic [CMP_BITS-1:0]   trig_ext;
    logic [CMP_BITS-1:0]   echo_ext;
    logic                  echo_ok;
    logic [15:0]           echo16;
    logic [PROD_BITS-1:0]  lvl_prod;

    logic [12:0] max_plus;
    logic [12:0] min_plus;
    logic        rep_changed;
    logic [11:0] rep_val;

    erlwa_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_stall = skid_full;
    assign req_fire  = req_valid && !skid_full;

    // fast tick datapath
    assign trig_inc = (&trig_cnt_reg) ? trig_cnt_reg : trig_cnt_reg + 1'b1;
    assign echo_inc = (&echo_w_reg) ? echo_w_reg : echo_w_reg + 1'b1;
    assign trig_ext = CMP_BITS'(trig_inc);
    assign echo_ext = CMP_BITS'(echo_w_reg);
    assign echo_ok  = (echo_ext > CMP_BITS'(cfg.echo_min_ticks))
                   && (echo_ext < CMP_BITS'(cfg.echo_max_ticks));
    assign echo16   = echo_ext[15:0];
    assign lvl_prod = PROD_BITS'(echo16) * PROD_BITS'(erlwa_pkg::LEVEL_MUL);

    // slow tick datapath
    assign max_plus = {1'b0, max_lim_reg} + {6'd0, cfg.limit_step};
    assign min_plus = {1'b0, min_lim_reg} + {6'd0, cfg.limit_step};

    always_comb
    begin
        trig_cnt_next  = trig_cnt_reg;
        echo_w_next    = echo_w_reg;
        level_next     = level_reg;
        max_lim_next   = max_lim_reg;
        min_lim_next   = min_lim_reg;
        trig_pin_next  = trig_pin_reg;
        alarm_pin_next = alarm_pin_reg;
        rep_changed    = 1'b0;
        rep_val        = '0;

        if (!req_data.func)
        begin
            trig_pin_next = (trig_ext >= CMP_BITS'(cfg.trigger_start))
                         && (trig_ext <= CMP_BITS'(cfg.trigger_end));
            if (req_data.echo_high)
            begin
                echo_w_next   = echo_inc;
                trig_cnt_next = '0;
            end
            else
            begin
                trig_cnt_next = trig_inc;
                echo_w_next   = '0;
                if (echo_ok)
                begin
                    level_next = lvl_prod[erlwa_pkg::LEVEL_SHIFT+13:erlwa_pkg::LEVEL_SHIFT];
                end
            end
        end
        else
        begin
            if (req_data.key_max_up && (max_lim_reg < cfg.limit_ceiling))
            begin
                max_lim_next = (max_plus > {1'b0, cfg.limit_ceiling})
                             ? cfg.limit_ceiling : max_plus[11:0];
                rep_changed  = (max_lim_next != max_lim_reg);
                rep_val      = max_lim_next;
            end
            else if (req_data.key_max_down && (max_lim_reg > min_lim_reg))
            begin
                max_lim_next = ({1'b0, max_lim_reg} >= min_plus)
                             ? max_lim_reg - {5'd0, cfg.limit_step} : min_lim_reg;
                rep_changed  = (max_lim_next != max_lim_reg);
                rep_val      = max_lim_next;
            end
            else if (req_data.key_min_up && (min_lim_reg < max_lim_reg))
            begin
                min_lim_next = (min_plus > {1'b0, max_lim_reg})
                             ? max_lim_reg : min_plus[11:0];
                rep_changed  = (min_lim_next != min_lim_reg);
                rep_val      = min_lim_next;
            end
            else if (req_data.key_min_down && (min_lim_reg != 12'd0))
            begin
                min_lim_next = (min_lim_reg >= {5'd0, cfg.limit_step})
                             ? min_lim_reg - {5'd0, cfg.limit_step} : 12'd0;
                rep_changed  = (min_lim_next != min_lim_reg);
                rep_val      = min_lim_next;
            end
            alarm_pin_next = (level_reg < {2'd0, min_lim_next})
                          || (level_reg > {2'd0, max_lim_next});
        end
    end

    always_comb
    begin
        res_word.trigger_out  = trig_pin_next;
        res_word.alarm_out    = alarm_pin_next;
        res_word.level_mm     = level_next;
        res_word.report_valid = rep_changed;
        res_word.report_value = rep_changed ? rep_val : 12'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_cnt_reg  <= '0;
            echo_w_reg    <= '0;
            level_reg     <= '0;
            max_lim_reg   <= erlwa_pkg::MAX_LIMIT_RST;
            min_lim_reg   <= '0;
            trig_pin_reg  <= 1'b0;
            alarm_pin_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            trig_cnt_reg  <= trig_cnt_next;
            echo_w_reg    <= echo_w_next;
            level_reg     <= level_next;
            max_lim_reg   <= max_lim_next;
            min_lim_reg   <= min_lim_next;
            trig_pin_reg  <= trig_pin_next;
            alarm_pin_reg <= alarm_pin_next;
        end
    end

    erlwa_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (req_fire),
        .load_word (res_word),
        .full      (skid_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
